/* hw/rtl/multichannel_sine_tone_generator_unit_macros.svh */
// Assertion macros for the multichannel sine tone generator unit.
`ifndef MULTICHANNEL_SINE_TONE_GENERATOR_UNIT_MACROS_SVH
`define MULTICHANNEL_SINE_TONE_GENERATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define MSTG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, held off during reset.
`define MSTG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSTG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MSTG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/mstg_pkg.sv */
// Shared types, constants and tables of the sine tone generator.
`default_nettype none
package mstg_pkg;

    // request codes
    localparam logic REQ_GENERATE = 1'b0;
    localparam logic REQ_LOAD     = 1'b1;

    // register indexes
    localparam logic [7:0] REG_BYTES_PER_SAMPLE = 8'd0;
    localparam logic [7:0] REG_CHANNEL_COUNT    = 8'd1;
    localparam logic [7:0] REG_PHASE_INCREMENT  = 8'd2;
    localparam logic [7:0] REG_ATTENUATION_DB   = 8'd3;

    // CORDIC datapath
    localparam int CW            = 34;
    localparam int CORDIC_STEPS  = 30;
    localparam int CORDIC_START  = 652032874;
    localparam int Q_ONE_INT     = 1073741824;
    localparam int MAX_DB_STEPS  = 12;
    localparam int QUEUE_DEPTH   = 2;

    // angles in 2^-32 turn units
    localparam logic [31:0] TURN_ANGLES [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // full scale of the sample width over ten to the number of 20 dB steps
    localparam logic [30:0] MAXVAL_TABLE [4][MAX_DB_STEPS+1] = '{
        '{31'd127, 31'd12, 31'd1, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0,
          31'd0, 31'd0, 31'd0, 31'd0},
        '{31'd32767, 31'd3276, 31'd327, 31'd32, 31'd3, 31'd0, 31'd0, 31'd0,
          31'd0, 31'd0, 31'd0, 31'd0, 31'd0},
        '{31'd8388607, 31'd838860, 31'd83886, 31'd8388, 31'd838, 31'd83, 31'd8,
          31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0},
        '{31'd2147483647, 31'd214748364, 31'd21474836, 31'd2147483, 31'd214748,
          31'd21474, 31'd2147, 31'd214, 31'd21, 31'd2, 31'd0, 31'd0, 31'd0}
    };

    // frame settings derived from the configuration registers
    typedef struct packed {
        logic [1:0] nb_m1;   // bytes per sample minus one
        logic [2:0] ch_m1;   // channels per frame minus one
        logic [3:0] steps;   // whole 20 dB steps
    } t_cfg;

    // number of whole 20 dB steps, by threshold count
    function automatic logic [3:0] db_steps(input logic [7:0] db);
        logic [3:0] n;
        n = 4'd0;
        for (int t = 1; t <= MAX_DB_STEPS; t++) begin
            if (db >= 8'(20 * t)) n = n + 4'd1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/mstg_fifo.sv */
// Short queue of phase indexes between front and back.
`default_nettype none
module mstg_fifo #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0]  r_count;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop)      r_count <= r_count + CNTW'(1);
            else if (i_pop && !i_push) r_count <= r_count - CNTW'(1);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mstg_front.sv */
// Front part: takes requests, keeps the phase accumulator, queues indexes.
`default_nettype none
module mstg_front #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_req_type,
    input  logic [31:0]                i_phase_value,
    input  logic [31:0]                i_phase_increment,
    output logic                       o_push,
    output logic [SINE_TABLE_BITS-1:0] o_k,
    input  logic                       i_full
);
    import mstg_pkg::*;

    logic [PHASE_BITS-1:0] r_acc;
    logic                  w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (i_req_type == REQ_GENERATE);
    // index is taken before the advance
    assign o_k      = r_acc[PHASE_BITS-1 -: SINE_TABLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_accept) begin
            if (i_req_type == REQ_LOAD) r_acc <= PHASE_BITS'(i_phase_value);
            else r_acc <= r_acc + PHASE_BITS'(i_phase_increment);
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mstg_cordic.sv */
// Back part: iterative CORDIC sine, quadrant fold, clamp and amplitude scale.
`default_nettype none
module mstg_cordic #(
    parameter int SINE_TABLE_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mstg_pkg::t_cfg             i_cfg,
    input  logic                       i_k_valid,
    input  logic [SINE_TABLE_BITS-1:0] i_k,
    output logic                       o_k_ready,
    output logic                       o_word_valid,
    output logic [31:0]                o_word,
    input  logic                       i_word_ready
);
    import mstg_pkg::*;

    localparam int RW = SINE_TABLE_BITS - 2;
    localparam logic signed [CW-1:0] Q_ONE = CW'(Q_ONE_INT);

    typedef enum logic [2:0] {S_IDLE, S_ROT, S_SEL, S_MUL, S_OUT} t_state;

    t_state               r_state;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic [1:0]           r_q;
    logic [4:0]           r_iter;
    logic                 r_neg;
    logic [30:0]          r_mag;
    logic [30:0]          r_maxval;
    logic [61:0]          r_prod;

    logic signed [CW-1:0] w_dx, w_dy, w_ang, w_v, w_s, w_c, w_abs;
    logic [61:0]          w_prod;
    logic [31:0]          w_mag;

    always_comb begin
        w_dx  = r_y >>> r_iter;
        w_dy  = r_x >>> r_iter;
        w_ang = signed'(CW'(TURN_ANGLES[r_iter]));
        // quadrant fold: sin, cos, -sin, -cos
        w_v   = r_q[0] ? r_x : r_y;
        w_s   = r_q[1] ? -w_v : w_v;
        if (w_s > Q_ONE)       w_c = Q_ONE;
        else if (w_s < -Q_ONE) w_c = -Q_ONE;
        else                   w_c = w_s;
        w_abs  = (w_c < 0) ? -w_c : w_c;
        w_prod = r_mag * r_maxval;
        w_mag  = r_prod[61:30];
    end

    assign o_k_ready    = (r_state == S_IDLE);
    assign o_word_valid = (r_state == S_OUT);
    assign o_word       = r_neg ? (32'd0 - w_mag) : w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_k_valid) begin
                        r_x     <= CW'(CORDIC_START);
                        r_y     <= '0;
                        r_z     <= signed'(CW'({i_k[RW-1:0], {(32-SINE_TABLE_BITS){1'b0}}}));
                        r_q     <= i_k[SINE_TABLE_BITS-1 -: 2];
                        r_iter  <= '0;
                        r_state <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_ang;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_ang;
                    end
                    if (r_iter == 5'(CORDIC_STEPS - 1)) r_state <= S_SEL;
                    else r_iter <= r_iter + 5'd1;
                end
                S_SEL: begin
                    r_mag    <= w_abs[30:0];
                    r_neg    <= (w_c < 0);
                    r_maxval <= MAXVAL_TABLE[i_cfg.nb_m1][i_cfg.steps];
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_word_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/mstg_serial.sv */
// Back part: splits each sample into bytes for every channel of the frame.
`default_nettype none
module mstg_serial (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mstg_pkg::t_cfg i_cfg,
    input  logic           i_word_valid,
    input  logic [31:0]    i_word,
    output logic           o_word_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_data_byte,
    output logic [2:0]     o_channel_index,
    output logic           o_last_of_frame
);
    import mstg_pkg::*;

    logic        r_valid;
    logic [31:0] r_word;
    logic [1:0]  r_byte;
    logic [2:0]  r_chan;
    logic        w_byte_last, w_last, w_take;

    assign w_byte_last     = (r_byte == i_cfg.nb_m1);
    assign w_last          = w_byte_last && (r_chan == i_cfg.ch_m1);
    assign w_take          = r_valid && i_ready;
    // next sample goes in as the final byte leaves
    assign o_word_ready    = !r_valid || (w_take && w_last);
    assign o_valid         = r_valid;
    assign o_data_byte     = r_word[{r_byte, 3'b000} +: 8];
    assign o_channel_index = r_chan;
    assign o_last_of_frame = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_byte  <= '0;
            r_chan  <= '0;
        end else if (o_word_ready && i_word_valid) begin
            r_valid <= 1'b1;
            r_word  <= i_word;
            r_byte  <= '0;
            r_chan  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else if (w_byte_last) begin
                r_byte <= '0;
                r_chan <= r_chan + 3'd1;
            end else begin
                r_byte <= r_byte + 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/multichannel_sine_tone_generator_unit.sv */
// Top level of the multichannel sine tone generator: registers, front, queue, back.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  request  | i_valid / o_ready        | i_req_type, i_phase_value
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//  byte out | o_valid / i_ready        | o_data_byte, o_channel_index,
//           |                          | o_last_of_frame
//
// A load item is taken by the front and yields nothing.
// A generate item passes through the CORDIC unit as start, 30 rotations,
// fold/clamp, multiply and hand-off; bytes then leave one per cycle while i_ready
// is high, and the CORDIC unit can work on the next sample while they leave.
// The front keeps taking items while the two-entry queue has room; the
// serialiser takes the next sample as the last byte of a frame leaves.
// Reset is synchronous, active low; no clearing pass is needed.
`default_nettype none
`include "multichannel_sine_tone_generator_unit_macros.svh"
module multichannel_sine_tone_generator_unit #(
    parameter int MAX_CHANNELS    = 8,
    parameter int SINE_TABLE_BITS = 12,
    parameter int PHASE_BITS      = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // requests
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_phase_value,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // byte stream
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_channel_index,
    output logic        o_last_of_frame
);
    import mstg_pkg::*;

    // channels per frame never exceed eight: the index port is three bits
    localparam int CH_LIMIT = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;

    // configuration registers
    logic [2:0]  r_bytes_per_sample;
    logic [3:0]  r_channel_count;
    logic [31:0] r_phase_increment;
    logic [7:0]  r_attenuation_db;

    t_cfg                       w_cfg;
    logic                       w_push, w_pop, w_q_full, w_q_empty;
    logic [SINE_TABLE_BITS-1:0] w_k_in, w_k_out;
    logic                       w_k_ready;
    logic                       w_word_valid, w_word_ready;
    logic [31:0]                w_word;

    // writes are always accepted; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_sample <= 3'd2;
            r_channel_count    <= 4'd2;
            r_phase_increment  <= 32'd42852281;
            r_attenuation_db   <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_BYTES_PER_SAMPLE: r_bytes_per_sample <= i_cfg_data[2:0];
                REG_CHANNEL_COUNT:    r_channel_count    <= i_cfg_data[3:0];
                REG_PHASE_INCREMENT:  r_phase_increment  <= i_cfg_data;
                REG_ATTENUATION_DB:   r_attenuation_db   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // out-of-range widths and counts are folded into range here
    always_comb begin
        if (r_bytes_per_sample == 3'd0)     w_cfg.nb_m1 = 2'd0;
        else if (r_bytes_per_sample > 3'd4) w_cfg.nb_m1 = 2'd3;
        else                                w_cfg.nb_m1 = 2'(r_bytes_per_sample - 3'd1);

        if (r_channel_count == 4'd0)                w_cfg.ch_m1 = 3'd0;
        else if (r_channel_count > 4'(CH_LIMIT))    w_cfg.ch_m1 = 3'(CH_LIMIT - 1);
        else                                        w_cfg.ch_m1 = 3'(r_channel_count - 4'd1);

        w_cfg.steps = db_steps(r_attenuation_db);
    end

    // front: accepts requests, owns the phase accumulator
    mstg_front #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_req_type        (i_req_type),
        .i_phase_value     (i_phase_value),
        .i_phase_increment (r_phase_increment),
        .o_push            (w_push),
        .o_k               (w_k_in),
        .i_full            (w_q_full)
    );

    // queue of table indexes decoupling front from back
    mstg_fifo #(
        .WIDTH (SINE_TABLE_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_k_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_k_out),
        .o_empty (w_q_empty)
    );

    assign w_pop = !w_q_empty && w_k_ready;

    // back: sine and scaling
    mstg_cordic #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_cordic (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_k_valid    (!w_q_empty),
        .i_k          (w_k_out),
        .o_k_ready    (w_k_ready),
        .o_word_valid (w_word_valid),
        .o_word       (w_word),
        .i_word_ready (w_word_ready)
    );

    // back: byte serialiser with its own output register
    mstg_serial u_serial (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_word_valid    (w_word_valid),
        .i_word          (w_word),
        .o_word_ready    (w_word_ready),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_data_byte     (o_data_byte),
        .o_channel_index (o_channel_index),
        .o_last_of_frame (o_last_of_frame)
    );

    // checks
    `MSTG_ASSERT_IMP(a_last_on_final_channel, i_clk, i_rst_n, o_valid && o_last_of_frame, o_channel_index == w_cfg.ch_m1, "frame end not on final channel")
    `MSTG_ASSERT_IMP(a_load_not_queued, i_clk, i_rst_n, i_valid && o_ready && (i_req_type == REQ_LOAD), !w_push, "load item entered the queue")
    `MSTG_ASSERT_IMP(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_q_empty, "pop from empty queue")
    `MSTG_ASSERT_NXT(a_frame_starts_at_zero, i_clk, i_rst_n, w_word_valid && w_word_ready, o_valid && (o_channel_index == 3'd0), "new frame not at channel zero")
endmodule
`default_nettype wire
